[rtl/core/conservative_pstate_governor_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the conservative P-state governor
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef CONSERVATIVE_PSTATE_GOVERNOR_MACROS_SVH
`define CONSERVATIVE_PSTATE_GOVERNOR_MACROS_SVH

`ifndef ASSERT_OFF
// Assert a property on a given clock, disabled while the given reset is low
`define CPG_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Assert a property on the block clock and reset
`define CPG_ASSERT(lbl, prop, msg) \
    `CPG_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)
`else
`define CPG_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define CPG_ASSERT(lbl, prop, msg)
`endif

`endif

[rtl/core/cpg_pkg.sv]
// ----------------------------------------------------------------------------
// cpg_pkg
// Shared types and constants of the conservative P-state governor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpg_pkg;

    // Sizing
    localparam int NUM_CPUS    = 64;
    localparam int CPU_AW      = 6;
    localparam int MAX_PSTATES = 16;
    localparam int PSTATE_LIM  = (MAX_PSTATES < 16) ? MAX_PSTATES : 16;

    // Width of the shared adder: holds 100 times a 64-bit delta
    localparam int ALU_W = 72;

    // floor(p / 100) for p below 2048 as (p * 1311) >> 17
    localparam int RECIP_100 = 1311;
    localparam int RECIP_SH  = 17;

    localparam logic [6:0] LOAD_FULL = 7'd100;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_ENABLE      = 3'd0,
        REG_UP_THRESH   = 3'd1,
        REG_DOWN_THRESH = 3'd2,
        REG_STEP_PCT    = 3'd3,
        REG_MIN_INTERVAL = 3'd4,
        REG_STATE_COUNT = 3'd5
    } cpg_reg_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } cpg_alu_op_t;

    // Per-CPU governor state row
    typedef struct packed {
        logic [63:0] base_mperf;
        logic [63:0] base_aperf;
        logic [63:0] last_raise;
        logic [63:0] last_lower;
        logic [1:0]  low_cnt;
    } cpg_row_t;

endpackage

`default_nettype wire

[rtl/core/cpg_alu.sv]
// ----------------------------------------------------------------------------
// cpg_alu
// Shared add/subtract unit; carry out on subtract means a >= b.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpg_alu import cpg_pkg::*; (
    input  logic [ALU_W-1:0] op_a,
    input  logic [ALU_W-1:0] op_b,
    input  cpg_alu_op_t      op,
    output logic [ALU_W-1:0] sum,
    output logic             carry
);

    logic [ALU_W:0]   full;
    logic [ALU_W-1:0] b_eff;
    logic             cin;

    // Two's complement subtract as add of inverted operand plus one
    assign cin   = (op == ALU_SUB);
    assign b_eff = cin ? ~op_b : op_b;
    assign full  = {1'b0, op_a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, cin};
    assign sum   = full[ALU_W-1:0];
    assign carry = full[ALU_W];

endmodule

`default_nettype wire

[rtl/core/conservative_pstate_governor.sv]
// ----------------------------------------------------------------------------
// conservative_pstate_governor
// Per-CPU conservative P-state governor: load from MPERF/APERF deltas,
// thresholds with rate limits, one decision per sample.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake            | Payload
//  s_      | in  | s_tvalid / s_tready  | sample: cpu, mperf, aperf, tick, pstate
//  m_      | out | m_tvalid / m_tready  | decision: next pstate, changed, load
//  apb     | in  | psel/penable/pready  | six configuration registers
//
//  An enabled sample goes through the single 72-bit adder, which forms both
//  deltas, 100 times the APERF delta, seven restoring division steps and two
//  tick differences; a load of 0 or full skips the multiply and the division.
//  A disabled sample goes straight to the output state. No item is taken until the
//  previous one is finished. The result waits in an output register while
//  m_tready is low. Reset clears the per-CPU row valid bits at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "conservative_pstate_governor_macros.svh"

module conservative_pstate_governor import cpg_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // cpu_index[5:0], mperf_count[69:6], aperf_count[133:70],
    // now_tick[197:134], current_pstate[201:198], zero fill above
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [207:0] s_tdata,
    // next_pstate[3:0], changed[4], measured_load[11:5], zero fill above
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,
    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DM, ST_DA, ST_CMP, ST_M1, ST_M2, ST_DIV,
        ST_RR, ST_RL, ST_DEC, ST_OUT
    } state_t;

    // Configuration registers
    logic        enable_reg;
    logic [6:0]  up_thr_reg;
    logic [6:0]  down_thr_reg;
    logic [6:0]  step_pct_reg;
    logic [9:0]  min_int_reg;
    logic [4:0]  state_cnt_reg;

    // Sequencer and working registers
    state_t      state_reg;
    logic [CPU_AW-1:0] cpu_reg;
    logic [63:0] mperf_reg;
    logic [63:0] aperf_reg;
    logic [63:0] now_reg;
    logic [3:0]  cur_reg;
    logic [4:0]  n_reg;
    logic [63:0] dm_reg;
    logic [63:0] da_reg;
    logic        dz_reg;
    logic [ALU_W-1:0] acc_reg;
    logic [63:0] rem_reg;
    logic [2:0]  cnt_reg;
    logic [5:0]  q_reg;
    logic [6:0]  load_reg;
    logic [11:0] prod_reg;
    logic [4:0]  step_reg;
    logic        rr_ok_reg;
    logic        rl_ok_reg;
    logic [3:0]  res_next_reg;
    logic        res_chg_reg;
    logic [6:0]  res_load_reg;

    // Output register
    logic        m_tvalid_reg;
    logic [3:0]  out_next_reg;
    logic        out_chg_reg;
    logic [6:0]  out_load_reg;

    // Per-CPU state memory with one valid bit per row
    cpg_row_t    row_mem [NUM_CPUS];
    cpg_row_t    row_rd_reg;
    logic [NUM_CPUS-1:0] vld_reg;
    logic        row_vld_reg;
    cpg_row_t    row_q;
    cpg_row_t    row_new;

    // Input unpacking
    logic [CPU_AW-1:0] in_cpu;
    logic [CPU_AW-1:0] in_cpu_idx;
    logic [63:0] in_mperf;
    logic [63:0] in_aperf;
    logic [63:0] in_now;
    logic [3:0]  in_cur;
    logic [4:0]  n_clamp;
    logic        s_acc;
    logic        out_free;
    logic        cfg_wr;

    // Shared adder
    logic [ALU_W-1:0] alu_a;
    logic [ALU_W-1:0] alu_b;
    cpg_alu_op_t      alu_op;
    logic [ALU_W-1:0] alu_sum;
    logic             alu_carry;
    logic             rate_ok;
    logic [6:0]       num_low;
    logic [22:0]      step_prod;
    logic [4:0]       step_raw;

    // Decision logic
    logic [3:0]  cur_c;
    logic [3:0]  dec_next;
    logic        dec_chg;
    logic [1:0]  dec_cnt;
    logic [63:0] dec_raise;
    logic [63:0] dec_lower;
    logic [1:0]  cnt_inc;
    logic [5:0]  sum_up;
    logic [4:0]  n_max;

    assign in_cpu   = s_tdata[5:0];
    assign in_mperf = s_tdata[69:6];
    assign in_aperf = s_tdata[133:70];
    assign in_now   = s_tdata[197:134];
    assign in_cur   = s_tdata[201:198];

    assign in_cpu_idx = ({1'b0, in_cpu} >= 7'(NUM_CPUS)) ? '0 : in_cpu;
    assign n_clamp    = (state_cnt_reg > 5'(PSTATE_LIM)) ? 5'(PSTATE_LIM) : state_cnt_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, out_load_reg, out_chg_reg, out_next_reg};

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            up_thr_reg    <= 7'd80;
            down_thr_reg  <= 7'd20;
            step_pct_reg  <= 7'd5;
            min_int_reg   <= 10'd10;
            state_cnt_reg <= 5'd16;
        end else if (cfg_wr) begin
            unique case (cpg_reg_t'(paddr[4:2]))
                REG_ENABLE:       enable_reg    <= pwdata[0];
                REG_UP_THRESH:    up_thr_reg    <= pwdata[6:0];
                REG_DOWN_THRESH:  down_thr_reg  <= pwdata[6:0];
                REG_STEP_PCT:     step_pct_reg  <= pwdata[6:0];
                REG_MIN_INTERVAL: min_int_reg   <= pwdata[9:0];
                REG_STATE_COUNT:  state_cnt_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cpg_reg_t'(paddr[4:2]))
            REG_ENABLE:       prdata = {31'b0, enable_reg};
            REG_UP_THRESH:    prdata = {25'b0, up_thr_reg};
            REG_DOWN_THRESH:  prdata = {25'b0, down_thr_reg};
            REG_STEP_PCT:     prdata = {25'b0, step_pct_reg};
            REG_MIN_INTERVAL: prdata = {22'b0, min_int_reg};
            REG_STATE_COUNT:  prdata = {27'b0, state_cnt_reg};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared adder operand select
    // ------------------------------------------------------------------
    assign row_q   = row_vld_reg ? row_rd_reg : '0;
    assign num_low = acc_reg[6:0];

    always_comb begin
        alu_a  = '0;
        alu_b  = '0;
        alu_op = ALU_ADD;
        unique case (state_reg)
            ST_DM: begin
                alu_a  = {8'b0, mperf_reg};
                alu_b  = {8'b0, row_q.base_mperf};
                alu_op = ALU_SUB;
            end
            ST_DA: begin
                alu_a  = {8'b0, aperf_reg};
                alu_b  = {8'b0, row_q.base_aperf};
                alu_op = ALU_SUB;
            end
            ST_CMP: begin
                alu_a  = {8'b0, da_reg};
                alu_b  = {8'b0, dm_reg};
                alu_op = ALU_SUB;
            end
            ST_M1: begin
                alu_a = {2'b0, da_reg, 6'b0};
                alu_b = {3'b0, da_reg, 5'b0};
            end
            ST_M2: begin
                alu_a = acc_reg;
                alu_b = {6'b0, da_reg, 2'b0};
            end
            ST_DIV: begin
                alu_a  = {7'b0, rem_reg, num_low[cnt_reg]};
                alu_b  = {8'b0, dm_reg};
                alu_op = ALU_SUB;
            end
            ST_RR: begin
                alu_a  = {8'b0, now_reg};
                alu_b  = {8'b0, row_q.last_raise};
                alu_op = ALU_SUB;
            end
            ST_RL: begin
                alu_a  = {8'b0, now_reg};
                alu_b  = {8'b0, row_q.last_lower};
                alu_op = ALU_SUB;
            end
            default: ;
        endcase
    end

    cpg_alu u_alu (
        .op_a  (alu_a),
        .op_b  (alu_b),
        .op    (alu_op),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    // Tick difference must be non-negative as signed and reach the interval
    assign rate_ok = !alu_sum[63] &&
                     ((alu_sum[62:10] != '0) || (alu_sum[9:0] >= min_int_reg));

    // Step = floor(n * percent / 100) through the reciprocal, at least one
    assign step_prod = 23'(prod_reg) * 23'(RECIP_100);
    assign step_raw  = step_prod[RECIP_SH+4:RECIP_SH];

    // ------------------------------------------------------------------
    // Decision
    // ------------------------------------------------------------------
    always_comb begin
        cur_c     = ({1'b0, cur_reg} >= n_reg) ? 4'd0 : cur_reg;
        n_max     = n_reg - 5'd1;
        sum_up    = {2'b0, cur_c} + {1'b0, step_reg};
        cnt_inc   = (row_q.low_cnt == 2'd3) ? 2'd3 : row_q.low_cnt + 2'd1;
        dec_next  = cur_c;
        dec_chg   = 1'b0;
        dec_cnt   = 2'd0;
        dec_raise = row_q.last_raise;
        dec_lower = row_q.last_lower;
        priority if (load_reg >= up_thr_reg) begin
            // High load: move toward the fast end
            if (cur_c != 4'd0 && rr_ok_reg) begin
                dec_next  = ({1'b0, cur_c} > step_reg) ?
                            4'({1'b0, cur_c} - step_reg) : 4'd0;
                dec_chg   = 1'b1;
                dec_raise = now_reg;
            end
        end else if (load_reg <= down_thr_reg) begin
            // Low load: count samples, lower after two
            dec_cnt = cnt_inc;
            if (cnt_inc >= 2'd2 && ({1'b0, cur_c} + 5'd1 < n_reg) && rl_ok_reg) begin
                dec_next  = (sum_up > {1'b0, n_max}) ? n_max[3:0] : sum_up[3:0];
                dec_chg   = (dec_next != cur_c);
                if (dec_chg) begin
                    dec_lower = now_reg;
                end
                dec_cnt = 2'd0;
            end
        end else begin
            dec_cnt = 2'd0;
        end
        row_new.base_mperf = mperf_reg;
        row_new.base_aperf = aperf_reg;
        row_new.last_raise = dec_raise;
        row_new.last_lower = dec_lower;
        row_new.low_cnt    = dec_cnt;
    end

    // ------------------------------------------------------------------
    // State memory: read on acceptance, write back on decision
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            row_rd_reg <= row_mem[in_cpu_idx];
        end
        if (state_reg == ST_DEC) begin
            row_mem[cpu_reg] <= row_new;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            vld_reg      <= '0;
        end else begin
            // Drop the result once taken
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        cpu_reg     <= in_cpu_idx;
                        mperf_reg   <= in_mperf;
                        aperf_reg   <= in_aperf;
                        now_reg     <= in_now;
                        cur_reg     <= in_cur;
                        n_reg       <= n_clamp;
                        row_vld_reg <= vld_reg[in_cpu_idx];
                        if (!enable_reg || n_clamp == 5'd0) begin
                            // Bypass: report the current state unchanged
                            res_next_reg <= in_cur;
                            res_chg_reg  <= 1'b0;
                            res_load_reg <= 7'd0;
                            state_reg    <= ST_OUT;
                        end else begin
                            state_reg <= ST_DM;
                        end
                    end
                end
                ST_DM: begin
                    dm_reg    <= alu_sum[63:0];
                    prod_reg  <= 12'(n_reg) * 12'(step_pct_reg);
                    state_reg <= ST_DA;
                end
                ST_DA: begin
                    da_reg    <= alu_sum[63:0];
                    dz_reg    <= (dm_reg == '0);
                    step_reg  <= (step_raw == 5'd0) ? 5'd1 : step_raw;
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    priority if (dz_reg) begin
                        load_reg  <= 7'd0;
                        state_reg <= ST_RR;
                    end else if (alu_carry) begin
                        load_reg  <= LOAD_FULL;
                        state_reg <= ST_RR;
                    end else begin
                        state_reg <= ST_M1;
                    end
                end
                ST_M1: begin
                    acc_reg   <= alu_sum;
                    state_reg <= ST_M2;
                end
                ST_M2: begin
                    // Numerator is 100 * da; the top part is below dm
                    acc_reg   <= alu_sum;
                    rem_reg   <= alu_sum[70:7];
                    cnt_reg   <= 3'd6;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    // Restoring division, one quotient bit a cycle
                    rem_reg <= alu_carry ? alu_sum[63:0] : alu_a[63:0];
                    q_reg   <= {q_reg[4:0], alu_carry};
                    if (cnt_reg == 3'd0) begin
                        load_reg  <= {q_reg, alu_carry};
                        state_reg <= ST_RR;
                    end else begin
                        cnt_reg <= cnt_reg - 3'd1;
                    end
                end
                ST_RR: begin
                    rr_ok_reg <= rate_ok;
                    state_reg <= ST_RL;
                end
                ST_RL: begin
                    rl_ok_reg <= rate_ok;
                    state_reg <= ST_DEC;
                end
                ST_DEC: begin
                    vld_reg[cpu_reg] <= 1'b1;
                    res_next_reg     <= dec_next;
                    res_chg_reg      <= dec_chg;
                    res_load_reg     <= load_reg;
                    state_reg        <= ST_OUT;
                end
                ST_OUT: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        out_next_reg <= res_next_reg;
                        out_chg_reg  <= res_chg_reg;
                        out_load_reg <= res_load_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CPG_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "ready after accept")
    `CPG_ASSERT(a_div_rem_bound, (state_reg == ST_DIV) |-> (rem_reg < dm_reg), "remainder bound")
    `CPG_ASSERT(a_load_range, (state_reg == ST_OUT) && out_free |=> m_tvalid && (m_tdata[11:5] <= LOAD_FULL), "load range")

endmodule

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the conservative P-state governor. Streams sampling
// transactions through the block under several register settings. A
// scoreboard predicts each decision and compares it with the result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import cpg_pkg::*;

    localparam int STALL_LIMIT = 2000;

    // Sample transaction, cpu index in the lowest bits
    typedef struct packed {
        logic [5:0]  pad;
        logic [3:0]  pstate;
        logic [63:0] now_tick;
        logic [63:0] aperf;
        logic [63:0] mperf;
        logic [5:0]  cpu;
    } sample_t;

    // Decision transaction, next P-state in the lowest bits
    typedef struct packed {
        logic [6:0] load;
        logic       changed;
        logic [3:0] next_pstate;
    } decision_t;

    // Governor prediction: per-CPU baselines, rate-limit ticks, low-load counts
    class pstate_scoreboard;
        logic        cfg_enable;
        logic [6:0]  cfg_up;
        logic [6:0]  cfg_down;
        logic [6:0]  cfg_step;
        logic [9:0]  cfg_interval;
        logic [4:0]  cfg_states;
        logic [63:0] base_mperf [NUM_CPUS];
        logic [63:0] base_aperf [NUM_CPUS];
        logic [63:0] last_raise [NUM_CPUS];
        logic [63:0] last_lower [NUM_CPUS];
        logic [1:0]  low_cnt [NUM_CPUS];
        decision_t   decision_q[$];
        int          mismatches;

        function new();
            cfg_enable   = 1'b0;
            cfg_up       = 7'd80;
            cfg_down     = 7'd20;
            cfg_step     = 7'd5;
            cfg_interval = 10'd10;
            cfg_states   = 5'd16;
            mismatches   = 0;
            foreach (base_mperf[i]) begin
                base_mperf[i] = '0;
                base_aperf[i] = '0;
                last_raise[i] = '0;
                last_lower[i] = '0;
                low_cnt[i]    = '0;
            end
        endfunction

        function void write_reg(cpg_reg_t idx, logic [31:0] value);
            case (idx)
                REG_ENABLE:       cfg_enable   = value[0];
                REG_UP_THRESH:    cfg_up       = value[6:0];
                REG_DOWN_THRESH:  cfg_down     = value[6:0];
                REG_STEP_PCT:     cfg_step     = value[6:0];
                REG_MIN_INTERVAL: cfg_interval = value[9:0];
                REG_STATE_COUNT:  cfg_states   = value[4:0];
                default: ;
            endcase
        endfunction

        // Elapsed ticks must be non-negative as a signed value and reach the interval
        function bit interval_ok(logic [63:0] now_tick, logic [63:0] last_tick);
            logic [63:0] gap;
            gap = now_tick - last_tick;
            return !gap[63] && (gap >= {54'd0, cfg_interval});
        endfunction

        function void note_sample(sample_t smp);
            int          c;
            int          n;
            int          cur;
            int          nxt;
            int          step;
            bit          chg;
            logic [6:0]  load;
            logic [63:0] dm;
            logic [63:0] da;
            logic [71:0] quot;
            decision_t   d;
            c = smp.cpu;
            n = (cfg_states > PSTATE_LIM) ? PSTATE_LIM : cfg_states;
            // Disabled or no states: pass the current index through, touch nothing
            if (!cfg_enable || n == 0) begin
                d.next_pstate = smp.pstate;
                d.changed     = 1'b0;
                d.load        = '0;
                decision_q.push_back(d);
                return;
            end
            cur = (smp.pstate >= n) ? 0 : smp.pstate;

            // Load from wrapping deltas, exact floor, clamped at full
            dm = smp.mperf - base_mperf[c];
            da = smp.aperf - base_aperf[c];
            if (dm == 0) begin
                load = '0;
            end else if (da >= dm) begin
                load = LOAD_FULL;
            end else begin
                quot = ({8'd0, da} * 72'd100) / {8'd0, dm};
                load = quot[6:0];
            end
            base_mperf[c] = smp.mperf;
            base_aperf[c] = smp.aperf;

            step = (n * cfg_step) / 100;
            if (step < 1)
                step = 1;
            nxt = cur;
            chg = 1'b0;

            if (load >= cfg_up) begin
                // High load: move toward index 0 once the raise limit allows
                if (cur > 0 && interval_ok(smp.now_tick, last_raise[c])) begin
                    nxt = (cur > step) ? cur - step : 0;
                    if (nxt != cur) begin
                        last_raise[c] = smp.now_tick;
                        chg = 1'b1;
                    end
                end
                low_cnt[c] = '0;
            end else if (load <= cfg_down) begin
                // Low load: two samples in a row allow a step toward slower states
                if (low_cnt[c] != 2'd3)
                    low_cnt[c] = low_cnt[c] + 2'd1;
                if (low_cnt[c] >= 2'd2 && cur + 1 < n &&
                    interval_ok(smp.now_tick, last_lower[c])) begin
                    nxt = cur + step;
                    if (nxt > n - 1)
                        nxt = n - 1;
                    if (nxt != cur) begin
                        last_lower[c] = smp.now_tick;
                        chg = 1'b1;
                    end
                    low_cnt[c] = '0;
                end
            end else begin
                low_cnt[c] = '0;
            end

            d.next_pstate = nxt[3:0];
            d.changed     = chg;
            d.load        = load;
            decision_q.push_back(d);
        endfunction

        function void check_decision(decision_t got);
            decision_t want;
            if (decision_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected decision: next %0d changed %0d load %0d",
                             got.next_pstate, got.changed, got.load);
                return;
            end
            want = decision_q.pop_front();
            if (want.next_pstate != got.next_pstate || want.changed != got.changed ||
                want.load != got.load) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("decision mismatch: expected next %0d changed %0d load %0d, got next %0d changed %0d load %0d",
                             want.next_pstate, want.changed, want.load,
                             got.next_pstate, got.changed, got.load);
            end
        endfunction
    endclass

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [207:0] s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    logic [15:0]  m_tdata;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [4:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;

    pstate_scoreboard sb;
    logic [63:0]      tick_now [NUM_CPUS] = '{default: '0};
    bit               rx_idle = 1'b1;
    int               stall_left = 0;
    int               quiet_cycles = 0;

    conservative_pstate_governor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the result stream in random bursts while idling is on
    always @(posedge aclk) begin
        if (!aresetn || !rx_idle) begin
            stall_left = 0;
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check every accepted decision transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_decision(decision_t'(m_tdata[11:0]));
    end

    // Abort when neither stream moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("conservative_pstate_governor test failed");
                $finish;
            end
        end
    end

    task automatic apb_write(cpg_reg_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, value);
    endtask

    // Hold off new samples until every decision is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.decision_q.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic set_config(bit en, int up, int dn, int stp, int intv, int sc);
        wait_drained();
        apb_write(REG_ENABLE, 32'(en));
        apb_write(REG_UP_THRESH, 32'(up));
        apb_write(REG_DOWN_THRESH, 32'(dn));
        apb_write(REG_STEP_PCT, 32'(stp));
        apb_write(REG_MIN_INTERVAL, 32'(intv));
        apb_write(REG_STATE_COUNT, 32'(sc));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_sample(sample_t smp, bit may_idle);
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(smp);
        tick_now[smp.cpu] = smp.now_tick;
        if (may_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    function automatic sample_t mk(int cpu, logic [63:0] mp, logic [63:0] ap,
                                   logic [63:0] tick, int cur);
        sample_t smp;
        smp.pad      = '0;
        smp.cpu      = cpu[5:0];
        smp.mperf    = mp;
        smp.aperf    = ap;
        smp.now_tick = tick;
        smp.pstate   = cur[3:0];
        return smp;
    endfunction

    // Mostly well-formed samples aimed at a load class, some pure noise
    task automatic build_sample(output sample_t smp);
        int          kind;
        int          cpu;
        int          lim;
        int          pct;
        logic [63:0] k;
        logic [63:0] dm;
        logic [63:0] da;
        logic [63:0] dt;
        kind = $urandom_range(0, 99);
        cpu  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_CPUS - 1)
                                           : $urandom_range(0, 3);
        lim  = (sb.cfg_states == 0 || sb.cfg_states > 16) ? 16 : sb.cfg_states;
        smp.pad    = '0;
        smp.cpu    = cpu[5:0];
        smp.pstate = ($urandom_range(0, 7) == 0) ? 4'($urandom)
                                                 : 4'($urandom_range(0, lim - 1));
        if (kind < 10) begin
            smp.cpu      = 6'($urandom);
            smp.mperf    = {$urandom, $urandom};
            smp.aperf    = {$urandom, $urandom};
            smp.now_tick = {$urandom, $urandom};
            return;
        end

        // Pick a target load percent
        case ($urandom_range(0, 5))
            0, 1: pct = $urandom_range(0, sb.cfg_down);
            2:    pct = $urandom_range(sb.cfg_up, 100);
            3:    pct = $urandom_range(0, 100);
            default: begin
                case ($urandom_range(0, 3))
                    0:       pct = sb.cfg_up;
                    1:       pct = int'(sb.cfg_up) - 1;
                    2:       pct = sb.cfg_down;
                    default: pct = int'(sb.cfg_down) + 1;
                endcase
            end
        endcase
        if (pct > 100)
            pct = 100;
        if (pct < 0)
            pct = 0;

        // Scale so that floor(100 * da / dm) lands on the target exactly
        if ($urandom_range(0, 1) == 0)
            k = $urandom_range(1, 1000);
        else
            k = ({$urandom, $urandom} >> $urandom_range(8, 40)) + 64'd1;
        dm = 64'd100 * k;
        da = 64'(pct) * k + ({$urandom, $urandom} % k);
        if (kind < 16)
            dm = '0;
        else if (kind < 22)
            da = dm + 64'($urandom_range(0, 500));
        smp.mperf = sb.base_mperf[cpu] + dm;
        smp.aperf = sb.base_aperf[cpu] + da;

        // Advance the tick, now and then backwards or far ahead
        case ($urandom_range(0, 19))
            0:       dt = '0;
            1:       dt = 64'd0 - 64'($urandom_range(1, 5000));
            2:       dt = {1'b1, 31'($urandom), 32'($urandom)};
            default: dt = 64'($urandom_range(0, 2 * sb.cfg_interval + 2));
        endcase
        smp.now_tick = tick_now[cpu] + dt;
    endtask

    task automatic run_phase(int count, bit idle);
        sample_t smp;
        rx_idle = idle;
        for (int i = 0; i < count; i++) begin
            build_sample(smp);
            send_sample(smp, idle);
        end
        wait_drained();
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: disabled after reset, then hand-picked corners
        rx_idle = 1'b0;
        send_sample(mk(63, '1, 64'd1, '1, 15), 1'b0);
        set_config(1'b1, 80, 20, 5, 10, 16);
        send_sample(mk(0, 64'd0, 64'd0, 64'd5, 3), 1'b0);
        send_sample(mk(0, 64'd0, 64'd0, 64'd100, 3), 1'b0);
        send_sample(mk(0, 64'd1000, 64'd1000, 64'd105, 4), 1'b0);
        send_sample(mk(0, 64'd2000, 64'd1800, 64'd110, 3), 1'b0);
        send_sample(mk(0, 64'd3000, 64'd2500, 64'd200, 0), 1'b0);
        send_sample(mk(0, 64'd4000, 64'd2700, 64'd210, 2), 1'b0);
        send_sample(mk(0, 64'd5000, 64'd2700, 64'd211, 2), 1'b0);
        send_sample(mk(1, '1, 64'h8000_0000_0000_0000, 64'd50, 15), 1'b0);
        send_sample(mk(1, 64'd5, 64'h8000_0000_0000_0003, 64'd60, 15), 1'b0);
        send_sample(mk(2, 64'd1000, 64'd999, 64'h8000_0000_0000_0032, 5), 1'b0);
        send_sample(mk(2, 64'd2000, 64'd1999, 64'h8000_0000_0000_0040, 0), 1'b0);
        send_sample(mk(3, 64'hFFFF_FFFF_FFFF_FF00, '1, '1, 15), 1'b0);
        // Oversized state count, full-range step, tightest thresholds
        set_config(1'b1, 100, 1, 100, 1, 31);
        send_sample(mk(4, 64'd100, 64'd0, 64'd1, 2), 1'b0);
        send_sample(mk(4, 64'd200, 64'd1, 64'd2, 2), 1'b0);
        send_sample(mk(4, 64'd300, 64'd300, 64'd3, 15), 1'b0);
        // Current index beyond the state count
        set_config(1'b1, 50, 30, 1, 1, 5);
        send_sample(mk(5, 64'd100, 64'd60, 64'd10, 9), 1'b0);
        // No states at all
        set_config(1'b1, 50, 30, 1, 1, 0);
        send_sample(mk(5, 64'd200, 64'd100, 64'd20, 9), 1'b0);

        // Random phases across settings, extremes included
        set_config(1'b1, 80, 20, 5, 10, 16);
        run_phase(200, 1'b1);
        set_config(1'b1, 100, 1, 100, 1, 16);
        run_phase(180, 1'b1);
        set_config(1'b1, 1, 100, 1, 1000, 1);
        run_phase(120, 1'b1);
        set_config(1'b0, 70, 30, 10, 5, 8);
        run_phase(60, 1'b1);
        set_config(1'b1, 70, 30, 10, 5, 0);
        run_phase(60, 1'b0);
        set_config(1'b1, 60, 40, 30, 3, 31);
        run_phase(200, 1'b1);
        repeat (3) begin
            set_config(1'b1, $urandom_range(1, 100), $urandom_range(1, 100),
                       $urandom_range(1, 100), $urandom_range(1, 40),
                       $urandom_range(2, 16));
            run_phase(190, 1'b1);
        end
        // Closing stretch with both streams running flat out
        set_config(1'b1, 75, 25, 20, 2, 12);
        run_phase(150, 1'b0);

        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.decision_q.size() == 0) begin
            $display("conservative_pstate_governor test passed");
        end else begin
            $display("conservative_pstate_governor test failed");
        end
        $finish;
    end

endmodule
